@@ hw/rtl/pvlm_pkg.sv @@
// Shared types and constants for the polyphonic voice list manager.
// No dependencies; imported by every module of the block.
package pvlm_pkg;

  // Default list depth and key width
  localparam int MAX_VOICES_DEF = 16;
  localparam int KEY_BITS_DEF   = 7;

  // Reset value of the keep-minimum register
  localparam int KEEP_MIN_RST = 3;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_KEY_ON  = 2'd0,
    CMD_KEY_OFF = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_PRUNE   = 2'd3
  } cmd_e;

  // Result event codes
  typedef enum logic [2:0] {
    EV_STARTED   = 3'd0,
    EV_CANCELLED = 3'd1,
    EV_RELEASED  = 3'd2,
    EV_NOCHANGE  = 3'd3,
    EV_REMOVED   = 3'd4,
    EV_FULL      = 3'd5
  } ev_e;

  // Per-cycle operation applied to a whole chain of key cells
  typedef struct packed {
    logic rotate;  // every cell takes its upper neighbor, top takes cell 0
    logic drop;    // cells at or above the drop position take their upper neighbor
    logic append;  // cell at the append position loads the new key
  } chain_op_t;

endpackage

@@ hw/rtl/pvlm_cell.sv @@
// One key cell of a list chain: a key register that holds, takes its
// upper neighbor's key, or loads a new key. Depends on pvlm_pkg.
module pvlm_cell import pvlm_pkg::*; #(
  parameter int MAX_VOICES = MAX_VOICES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int INDEX      = 0,
  localparam int IDX_W     = $clog2(MAX_VOICES),
  localparam int CNT_W     = $clog2(MAX_VOICES + 1)
) (
  input  logic                clk_i,
  input  chain_op_t           op_i,
  input  logic [IDX_W-1:0]    drop_pos_i,
  input  logic [CNT_W-1:0]    append_pos_i,
  input  logic [KEY_BITS-1:0] up_key_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  output logic [KEY_BITS-1:0] key_o
);

  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_d;
  logic                take;
  logic                load;

  // Decide from this cell's own position what it does this cycle
  assign take = op_i.rotate || (op_i.drop && (IDX_W'(INDEX) >= drop_pos_i));
  assign load = op_i.append && (append_pos_i == CNT_W'(INDEX));

  always_comb begin
    key_d = key_q;
    if (load) begin
      key_d = new_key_i;
    end else if (take) begin
      key_d = up_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

@@ hw/rtl/pvlm_chain.sv @@
// A ring of key cells holding one list, entry i in cell i, plus the match
// logic at the head cell used while the ring rotates. Depends on pvlm_pkg, pvlm_cell.
module pvlm_chain import pvlm_pkg::*; #(
  parameter int MAX_VOICES = MAX_VOICES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  localparam int IDX_W     = $clog2(MAX_VOICES),
  localparam int CNT_W     = $clog2(MAX_VOICES + 1)
) (
  input  logic                clk_i,
  input  chain_op_t           op_i,
  input  logic [IDX_W-1:0]    drop_pos_i,
  input  logic [CNT_W-1:0]    append_pos_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [KEY_BITS-1:0] cmp_key_i,
  input  logic [IDX_W-1:0]    scan_i,
  input  logic [CNT_W-1:0]    count_i,
  output logic [KEY_BITS-1:0] head_o,
  output logic                hit_o
);

  logic [KEY_BITS-1:0] cell_key [MAX_VOICES];

  // Build the ring: each cell reads the cell above, the top reads cell 0
  for (genvar i = 0; i < MAX_VOICES; i++) begin : g_cell
    pvlm_cell #(
      .MAX_VOICES (MAX_VOICES),
      .KEY_BITS   (KEY_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .op_i         (op_i),
      .drop_pos_i   (drop_pos_i),
      .append_pos_i (append_pos_i),
      .up_key_i     (cell_key[(i + 1) % MAX_VOICES]),
      .new_key_i    (new_key_i),
      .key_o        (cell_key[i])
    );
  end

  // The head holds entry scan_i during a rotation; it counts only below the fill
  assign head_o = cell_key[0];
  assign hit_o  = (cell_key[0] == cmp_key_i) && (CNT_W'(scan_i) < count_i);

endmodule

@@ hw/rtl/polyphonic_voice_list_manager_core.sv @@
// Polyphonic voice list manager: a sounding-key list and an oldest-first
// released-key list, each a ring of MAX_VOICES key cells, one request at a time.
// Depends on pvlm_pkg, pvlm_chain.
//
// Each list is searched by rotating its ring once past a single comparator at
// the head cell. A key-on, key-off or voice-finished request scans both rings
// in S_SCAN, then updates the lists and loads the result in S_APPLY. A prune
// with nothing to drop goes straight to S_PDONE; otherwise each of the E oldest
// released entries dropped (at most MAX_VOICES) needs one full rotation of the
// sounding list in S_PSCAN and a drop in S_PDROP before S_PDONE. S_APPLY and
// S_PDONE wait while the output slot is full, S_PDROP only to hand out a held
// removal. One result register sits on the output, so a new request is taken
// while the last result waits. No clearing pass follows reset.
module polyphonic_voice_list_manager_core import pvlm_pkg::*; #(
  parameter int MAX_VOICES = MAX_VOICES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  localparam int IDX_W     = $clog2(MAX_VOICES),
  localparam int CNT_W     = $clog2(MAX_VOICES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel (keep minimum)
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CNT_W-1:0]    cfg_data_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [KEY_BITS-1:0] key_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KEY_BITS-1:0] key_out_o,
  output logic [2:0]          event_res_o,
  output logic [CNT_W-1:0]    playing_count_o,
  output logic [CNT_W-1:0]    released_count_o,
  output logic                last_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_APPLY = 6'b000100,
    S_PSCAN = 6'b001000,
    S_PDROP = 6'b010000,
    S_PDONE = 6'b100000
  } state_e;

  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(MAX_VOICES);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_VOICES - 1);

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic                p_hit_q, p_hit_d;
  logic [IDX_W-1:0]    p_pos_q, p_pos_d;
  logic                r_hit_q, r_hit_d;
  logic [IDX_W-1:0]    r_pos_q, r_pos_d;
  logic [CNT_W-1:0]    pcount_q, pcount_d;
  logic [CNT_W-1:0]    rcount_q, rcount_d;
  logic [CNT_W-1:0]    keep_q;
  logic [CNT_W-1:0]    excess_q, excess_d;
  logic [CNT_W-1:0]    rcfin_q, rcfin_d;
  logic                pend_valid_q, pend_valid_d;
  logic [KEY_BITS-1:0] pend_key_q, pend_key_d;
  logic [CNT_W-1:0]    pend_pc_q, pend_pc_d;

  logic                res_valid_q;
  logic                res_load;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;
  ev_e                 res_event_q, res_event_d;
  logic [CNT_W-1:0]    res_pc_q, res_pc_d;
  logic [CNT_W-1:0]    res_rc_q, res_rc_d;
  logic                res_last_q, res_last_d;

  chain_op_t           p_op, r_op;
  logic [IDX_W-1:0]    r_drop_pos;
  logic [KEY_BITS-1:0] p_head, r_head, p_cmp_key;
  logic                p_hit, r_hit;
  logic                slot_free;
  logic                scan_end;
  logic [CNT_W-1:0]    over;
  logic [CNT_W-1:0]    excess_new;

  // Output slot can take a new result when empty or being emptied
  assign slot_free = !res_valid_q || out_ready_i;
  assign scan_end  = (cnt_q == LastIdx);

  // Prune size: sounding voices above the minimum, capped by the released count
  assign over       = pcount_q - keep_q;
  assign excess_new = (pcount_q > keep_q) ? ((over > rcount_q) ? rcount_q : over) : '0;

  // Sounding list compares against the request key, or the oldest release when pruning
  assign p_cmp_key = (state_q == S_PSCAN) ? r_head : key_q;

  pvlm_chain #(
    .MAX_VOICES (MAX_VOICES),
    .KEY_BITS   (KEY_BITS)
  ) u_play (
    .clk_i        (clk_i),
    .op_i         (p_op),
    .drop_pos_i   (p_pos_q),
    .append_pos_i (pcount_q),
    .new_key_i    (key_q),
    .cmp_key_i    (p_cmp_key),
    .scan_i       (cnt_q),
    .count_i      (pcount_q),
    .head_o       (p_head),
    .hit_o        (p_hit)
  );

  pvlm_chain #(
    .MAX_VOICES (MAX_VOICES),
    .KEY_BITS   (KEY_BITS)
  ) u_rel (
    .clk_i        (clk_i),
    .op_i         (r_op),
    .drop_pos_i   (r_drop_pos),
    .append_pos_i (rcount_q),
    .new_key_i    (key_q),
    .cmp_key_i    (key_q),
    .scan_i       (cnt_q),
    .count_i      (rcount_q),
    .head_o       (r_head),
    .hit_o        (r_hit)
  );

  // Sequencer: scan the rings, apply the update, hand out the results
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    p_hit_d      = p_hit_q;
    p_pos_d      = p_pos_q;
    r_hit_d      = r_hit_q;
    r_pos_d      = r_pos_q;
    pcount_d     = pcount_q;
    rcount_d     = rcount_q;
    excess_d     = excess_q;
    rcfin_d      = rcfin_q;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    pend_pc_d    = pend_pc_q;
    p_op         = '0;
    r_op         = '0;
    r_drop_pos   = r_pos_q;
    res_load     = 1'b0;
    res_key_d    = res_key_q;
    res_event_d  = res_event_q;
    res_pc_d     = res_pc_q;
    res_rc_d     = res_rc_q;
    res_last_d   = res_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(cmd_i);
          key_d   = key_i;
          cnt_d   = '0;
          p_hit_d = 1'b0;
          r_hit_d = 1'b0;
          if (cmd_e'(cmd_i) == CMD_PRUNE) begin
            excess_d = excess_new;
            rcfin_d  = rcount_q - excess_new;
            state_d  = (excess_new == '0) ? S_PDONE : S_PSCAN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // Rotate both rings once; keep the newest match of each
      S_SCAN: begin
        p_op.rotate = 1'b1;
        r_op.rotate = 1'b1;
        cnt_d       = cnt_q + IDX_W'(1);
        if (p_hit) begin
          p_hit_d = 1'b1;
          p_pos_d = cnt_q;
        end
        if (r_hit) begin
          r_hit_d = 1'b1;
          r_pos_d = cnt_q;
        end
        if (scan_end) begin
          cnt_d   = '0;
          state_d = S_APPLY;
        end
      end

      // Update the lists and load the single result
      S_APPLY: begin
        if (slot_free) begin
          res_event_d = EV_NOCHANGE;
          case (cmd_q)
            CMD_KEY_ON: begin
              if (p_hit_q) begin
                if (r_hit_q) begin
                  r_op.drop   = 1'b1;
                  rcount_d    = rcount_q - CNT_W'(1);
                  res_event_d = EV_CANCELLED;
                end
              end else if (pcount_q == FullCnt) begin
                res_event_d = EV_FULL;
              end else begin
                p_op.append = 1'b1;
                pcount_d    = pcount_q + CNT_W'(1);
                res_event_d = EV_STARTED;
              end
            end
            CMD_KEY_OFF: begin
              if (p_hit_q) begin
                if (rcount_q == FullCnt) begin
                  res_event_d = EV_FULL;
                end else begin
                  r_op.append = 1'b1;
                  rcount_d    = rcount_q + CNT_W'(1);
                  res_event_d = EV_RELEASED;
                end
              end
            end
            CMD_FINISH: begin
              if (p_hit_q) begin
                p_op.drop   = 1'b1;
                pcount_d    = pcount_q - CNT_W'(1);
                res_event_d = EV_REMOVED;
              end
              if (r_hit_q) begin
                r_op.drop   = 1'b1;
                rcount_d    = rcount_q - CNT_W'(1);
                res_event_d = EV_REMOVED;
              end
            end
            default: begin
              res_event_d = EV_NOCHANGE;
            end
          endcase
          res_load   = 1'b1;
          res_key_d  = key_q;
          res_pc_d   = pcount_d;
          res_rc_d   = rcount_d;
          res_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // Rotate the sounding ring looking for the oldest release
      S_PSCAN: begin
        p_op.rotate = 1'b1;
        cnt_d       = cnt_q + IDX_W'(1);
        if (p_hit) begin
          p_hit_d = 1'b1;
          p_pos_d = cnt_q;
        end
        if (scan_end) begin
          cnt_d   = '0;
          state_d = S_PDROP;
        end
      end

      // Drop the oldest release; a sounding match becomes the pending result
      S_PDROP: begin
        if (!(p_hit_q && pend_valid_q && !slot_free)) begin
          if (p_hit_q) begin
            if (pend_valid_q) begin
              res_load    = 1'b1;
              res_key_d   = pend_key_q;
              res_event_d = EV_REMOVED;
              res_pc_d    = pend_pc_q;
              res_rc_d    = rcfin_q;
              res_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_key_d   = r_head;
            pend_pc_d    = pcount_q - CNT_W'(1);
            p_op.drop    = 1'b1;
            pcount_d     = pcount_q - CNT_W'(1);
          end
          r_op.drop  = 1'b1;
          r_drop_pos = '0;
          rcount_d   = rcount_q - CNT_W'(1);
          excess_d   = excess_q - CNT_W'(1);
          p_hit_d    = 1'b0;
          state_d    = (excess_q == CNT_W'(1)) ? S_PDONE : S_PSCAN;
        end
      end

      // Close the prune with its final result
      S_PDONE: begin
        if (slot_free) begin
          res_load   = 1'b1;
          res_rc_d   = rcfin_q;
          res_last_d = 1'b1;
          if (pend_valid_q) begin
            res_key_d   = pend_key_q;
            res_event_d = EV_REMOVED;
            res_pc_d    = pend_pc_q;
          end else begin
            res_key_d   = '0;
            res_event_d = EV_NOCHANGE;
            res_pc_d    = pcount_q;
          end
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      p_hit_q      <= 1'b0;
      r_hit_q      <= 1'b0;
      pcount_q     <= '0;
      rcount_q     <= '0;
      keep_q       <= CNT_W'(KEEP_MIN_RST);
      excess_q     <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      p_hit_q      <= p_hit_d;
      r_hit_q      <= r_hit_d;
      pcount_q     <= pcount_d;
      rcount_q     <= rcount_d;
      excess_q     <= excess_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_valid_i) begin
        keep_q <= cfg_data_i;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    p_pos_q     <= p_pos_d;
    r_pos_q     <= r_pos_d;
    rcfin_q     <= rcfin_d;
    pend_key_q  <= pend_key_d;
    pend_pc_q   <= pend_pc_d;
    res_key_q   <= res_key_d;
    res_event_q <= res_event_d;
    res_pc_q    <= res_pc_d;
    res_rc_q    <= res_rc_d;
    res_last_q  <= res_last_d;
  end

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = res_valid_q;
  assign key_out_o        = res_key_q;
  assign event_res_o      = res_event_q;
  assign playing_count_o  = res_pc_q;
  assign released_count_o = res_rc_q;
  assign last_o           = res_last_q;

endmodule

@@ hw/rtl/pvlm_checker.sv @@
// Port-level checks for the voice list manager, bound to the top level.
// Depends on pvlm_pkg and polyphonic_voice_list_manager_core.
module pvlm_checker import pvlm_pkg::*; #(
  parameter int MAX_VOICES = MAX_VOICES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  localparam int CNT_W     = $clog2(MAX_VOICES + 1)
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [KEY_BITS-1:0] key_out_o,
  input logic [2:0]          event_res_o,
  input logic [CNT_W-1:0]    playing_count_o,
  input logic [CNT_W-1:0]    released_count_o,
  input logic                last_o
);

  // A stalled result holds its key, event, playing count and last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_out_o)
      && $stable(event_res_o) && $stable(playing_count_o) && $stable(last_o))
    else $error("stalled result changed");

  // The block works on one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // Counts never pass the list depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (playing_count_o <= CNT_W'(MAX_VOICES))
      && (released_count_o <= CNT_W'(MAX_VOICES)))
    else $error("count beyond list depth");

  // Only prune results may be non-final, and they report removals
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> event_res_o == EV_REMOVED)
    else $error("non-final result is not a removal");

  // A started key leaves at least one voice sounding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_STARTED) |-> playing_count_o != '0)
    else $error("started with no voice sounding");

endmodule

bind polyphonic_voice_list_manager_core pvlm_checker #(
  .MAX_VOICES (MAX_VOICES),
  .KEY_BITS   (KEY_BITS)
) u_pvlm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .key_out_o        (key_out_o),
  .event_res_o      (event_res_o),
  .playing_count_o  (playing_count_o),
  .released_count_o (released_count_o),
  .last_o           (last_o)
);

@@ dv/voice_list_checker.sv @@
`timescale 1ns / 100ps
// Checker for the voice list manager: watches the config, request and result
// channels, predicts the result stream and compares it. Depends on pvlm_pkg.
module voice_list_checker import pvlm_pkg::*; #(
  parameter int MAX_VOICES = MAX_VOICES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int CNT_W      = $clog2(MAX_VOICES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CNT_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          cmd_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [KEY_BITS-1:0] key_out_i,
  input  logic [2:0]          event_res_i,
  input  logic [CNT_W-1:0]    playing_count_i,
  input  logic [CNT_W-1:0]    released_count_i,
  input  logic                last_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    ev_e                 ev;
    logic [CNT_W-1:0]    pc;
    logic [CNT_W-1:0]    rc;
    logic                last_flag;
  } voice_event_t;

  voice_event_t        voice_events_due[$];
  logic [KEY_BITS-1:0] sounding_keys[MAX_VOICES];
  logic [KEY_BITS-1:0] released_keys[MAX_VOICES];
  int                  sounding_n;
  int                  released_n;
  int                  keep_min;
  int                  mismatches;

  // Search from the newest entry down, as the lists are scanned
  function automatic int find_sounding(logic [KEY_BITS-1:0] k);
    for (int i = sounding_n - 1; i >= 0; i--) begin
      if (sounding_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int find_released(logic [KEY_BITS-1:0] k);
    for (int i = released_n - 1; i >= 0; i--) begin
      if (released_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // Sounding list is unordered: move the top entry into the hole
  function automatic void drop_sounding(int pos);
    sounding_keys[pos] = sounding_keys[sounding_n-1];
    sounding_n--;
  endfunction

  // Released list keeps age order: close the gap
  function automatic void drop_released(int pos);
    for (int i = pos; i + 1 < released_n; i++) begin
      released_keys[i] = released_keys[i+1];
    end
    released_n--;
  endfunction

  function automatic void queue_event(logic [KEY_BITS-1:0] k, ev_e ev, int pc, int rc,
                                      logic last_flag);
    voice_event_t e;
    e.key       = k;
    e.ev        = ev;
    e.pc        = pc[CNT_W-1:0];
    e.rc        = rc[CNT_W-1:0];
    e.last_flag = last_flag;
    voice_events_due.push_back(e);
  endfunction

  // Apply one request to the list state and queue the events it produces
  function automatic void predict_voice_events(cmd_e cmd, logic [KEY_BITS-1:0] k);
    ev_e                 ev;
    int                  p;
    int                  r;
    int                  excess;
    int                  removed;
    logic [KEY_BITS-1:0] gone[MAX_VOICES];
    int                  pc_after[MAX_VOICES];
    ev = EV_NOCHANGE;
    case (cmd)
      CMD_KEY_ON: begin
        p = find_sounding(k);
        if (p >= 0) begin
          r = find_released(k);
          if (r >= 0) begin
            drop_released(r);
            ev = EV_CANCELLED;
          end
        end else if (sounding_n >= MAX_VOICES) begin
          ev = EV_FULL;
        end else begin
          sounding_keys[sounding_n] = k;
          sounding_n++;
          ev = EV_STARTED;
        end
      end
      CMD_KEY_OFF: begin
        if (find_sounding(k) >= 0) begin
          if (released_n >= MAX_VOICES) begin
            ev = EV_FULL;
          end else begin
            released_keys[released_n] = k;
            released_n++;
            ev = EV_RELEASED;
          end
        end
      end
      CMD_FINISH: begin
        p = find_sounding(k);
        if (p >= 0) begin
          drop_sounding(p);
          ev = EV_REMOVED;
        end
        r = find_released(k);
        if (r >= 0) begin
          drop_released(r);
          ev = EV_REMOVED;
        end
      end
      default: begin
        // Prune: drop the oldest releases up to the excess over keep_min
        excess  = 0;
        removed = 0;
        if (sounding_n > keep_min) begin
          excess = sounding_n - keep_min;
          if (excess > released_n) excess = released_n;
        end
        for (int j = 0; j < excess; j++) begin
          p = find_sounding(released_keys[j]);
          if (p >= 0) begin
            drop_sounding(p);
            gone[removed]     = released_keys[j];
            pc_after[removed] = sounding_n;
            removed++;
          end
        end
        for (int j = 0; j + excess < released_n; j++) begin
          released_keys[j] = released_keys[j+excess];
        end
        released_n -= excess;
        if (removed == 0) begin
          queue_event('0, EV_NOCHANGE, sounding_n, released_n, 1'b1);
        end else begin
          for (int j = 0; j < removed; j++) begin
            queue_event(gone[j], EV_REMOVED, pc_after[j], released_n, j == removed - 1);
          end
        end
        return;
      end
    endcase
    queue_event(k, ev, sounding_n, released_n, 1'b1);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare accepted results, then take config and requests of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    voice_event_t want;
    if (!rst_ni) begin
      voice_events_due.delete();
      sounding_n   = 0;
      released_n   = 0;
      keep_min     = KEEP_MIN_RST;
      mismatches   = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (voice_events_due.size() == 0) begin
          $error("result with no request pending: key_out %0d event_res %0d",
                 key_out_i, event_res_i);
          mismatches++;
        end else begin
          want = voice_events_due.pop_front();
          check_field("key_out", 8'(want.key), 8'(key_out_i));
          check_field("event_res", 8'(want.ev), 8'(event_res_i));
          check_field("playing_count", 8'(want.pc), 8'(playing_count_i));
          check_field("released_count", 8'(want.rc), 8'(released_count_i));
          check_field("last", 8'(want.last_flag), 8'(last_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) keep_min = int'(cfg_data_i);
      if (in_valid_i && in_ready_i) predict_voice_events(cmd_e'(cmd_i), key_i);
      mismatches_o <= mismatches;
      pending_o    <= voice_events_due.size();
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Top of the voice list manager bench: clock, reset, request stimulus, result
// stalls and verdict. Depends on pvlm_pkg, the core and voice_list_checker.
module tb;
  import pvlm_pkg::*;

  localparam int MAX_VOICES = MAX_VOICES_DEF;
  localparam int KEY_BITS   = KEY_BITS_DEF;
  localparam int CNT_W      = $clog2(MAX_VOICES + 1);
  localparam int RAND_ITEMS = 360;
  localparam int PHASE_LEN  = 45;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [1:0]          cmd_i       = '0;
  logic [KEY_BITS-1:0] key_i       = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [KEY_BITS-1:0] key_out_o;
  logic [2:0]          event_res_o;
  logic [CNT_W-1:0]    playing_count_o;
  logic [CNT_W-1:0]    released_count_o;
  logic                last_o;
  int                  mismatches;
  int                  pending;

  bit calm_send;
  int pool_base;
  int pool_size;
  int phase_sent;

  polyphonic_voice_list_manager_core #(
    .MAX_VOICES(MAX_VOICES),
    .KEY_BITS  (KEY_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .key_i           (key_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .key_out_o       (key_out_o),
    .event_res_o     (event_res_o),
    .playing_count_o (playing_count_o),
    .released_count_o(released_count_o),
    .last_o          (last_o)
  );

  voice_list_checker #(
    .MAX_VOICES(MAX_VOICES),
    .KEY_BITS  (KEY_BITS),
    .CNT_W     (CNT_W)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .cmd_i           (cmd_i),
    .key_i           (key_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .key_out_i       (key_out_o),
    .event_res_i     (event_res_o),
    .playing_count_i (playing_count_o),
    .released_count_i(released_count_o),
    .last_i          (last_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request, after a random gap unless calm_send, hold it until accepted
  task automatic send_voice_req(cmd_e c, logic [KEY_BITS-1:0] k);
    int gap;
    gap = calm_send ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    key_i      <= k;
    do @(posedge clk_i); while (!in_ready_o);
    phase_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_keep_min(int v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[CNT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [KEY_BITS-1:0] draw_pool_key();
    return KEY_BITS'(pool_base + $urandom_range(0, pool_size - 1));
  endfunction

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin
    int  stall;
    int  got;
    bit  held;
    got  = 0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = ((got / 40) % 3 == 1) ? 0 : $urandom_range(0, 6);
      if (!held && got >= 150 && in_valid_i) begin
        held  = 1'b1;
        stall = 300;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got++;
    end
  end

  // Request side: directed cases, then chord-shaped random phases
  initial begin
    int                  keep_set[8];
    int                  phase;
    int                  rand_sent;
    int                  n;
    int                  pick;
    logic [KEY_BITS-1:0] chord[MAX_VOICES];
    calm_send  = 1'b0;
    phase_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty lists, duplicates, re-release, cancel and a small prune
    send_voice_req(CMD_FINISH, 7'd5);
    send_voice_req(CMD_KEY_OFF, 7'd5);
    send_voice_req(CMD_PRUNE, 7'd127);
    send_voice_req(CMD_KEY_ON, 7'd0);
    send_voice_req(CMD_KEY_ON, 7'd127);
    send_voice_req(CMD_KEY_ON, 7'd0);
    send_voice_req(CMD_KEY_OFF, 7'd127);
    send_voice_req(CMD_KEY_OFF, 7'd127);
    send_voice_req(CMD_KEY_ON, 7'd127);
    send_voice_req(CMD_FINISH, 7'd127);
    send_voice_req(CMD_KEY_ON, 7'd1);
    send_voice_req(CMD_KEY_ON, 7'd2);
    send_voice_req(CMD_KEY_ON, 7'd3);
    send_voice_req(CMD_KEY_OFF, 7'd0);
    send_voice_req(CMD_KEY_OFF, 7'd1);
    send_voice_req(CMD_PRUNE, 7'd0);
    send_voice_req(CMD_PRUNE, 7'd85);
    send_voice_req(CMD_FINISH, 7'd1);
    send_voice_req(CMD_KEY_OFF, 7'd2);
    send_voice_req(CMD_KEY_OFF, 7'd3);
    write_keep_min(0);
    send_voice_req(CMD_PRUNE, 7'd42);

    // Settings per phase: high keep fills both lists, zero keep prunes deep
    keep_set = '{16, 0, 5, 16, 1, 0, 0, 0};
    keep_set[5] = $urandom_range(0, 16);
    keep_set[7] = $urandom_range(0, 16);
    rand_sent  = 0;
    phase      = 0;
    phase_sent = PHASE_LEN;
    while (rand_sent < RAND_ITEMS) begin
      if (phase_sent >= PHASE_LEN) begin
        rand_sent += phase_sent;
        if (phase > 0 && rand_sent >= RAND_ITEMS) break;
        write_keep_min(keep_set[phase % 8]);
        pool_size  = (keep_set[phase % 8] == 16) ? 28 : $urandom_range(4, 40);
        pool_base  = $urandom_range(0, 128 - pool_size);
        calm_send  = (phase % 4 == 2);
        phase_sent = 0;
        phase++;
      end
      // Chord: start a group of keys, then release, retake or finish most of them
      n = ($urandom_range(0, 7) == 0) ? MAX_VOICES : $urandom_range(1, 6);
      for (int j = 0; j < n; j++) begin
        chord[j] = draw_pool_key();
        send_voice_req(CMD_KEY_ON, chord[j]);
      end
      for (int j = 0; j < n; j++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) send_voice_req(CMD_KEY_OFF, chord[j]);
        if (pick == 0) send_voice_req(CMD_KEY_ON, chord[j]);
        if (pick == 7) send_voice_req(CMD_FINISH, chord[j]);
        if (pick == 9) send_voice_req(cmd_e'($urandom_range(0, 3)),
                                      KEY_BITS'($urandom_range(0, 127)));
      end
      // Close the batch with a prune most times, and now and then wait for idle
      if ($urandom_range(0, 4) != 0) begin
        send_voice_req(CMD_PRUNE, KEY_BITS'($urandom_range(0, 127)));
      end
      if ($urandom_range(0, 7) == 0) wait_idle();
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
